[rtl/mrc_pkg.sv]
// Shared types, constants and CRC helper for the metadata record checker.
// No dependencies; imported by every module under rtl/.
package mrc_pkg;

  localparam int unsigned NumWords   = 5;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueIdxW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [4:0]  RecLen      = 5'd26;
  localparam logic [4:0]  CountSat    = 5'd27;
  localparam logic [4:0]  MagicEnd    = 5'd4;
  localparam logic [4:0]  FieldEnd    = 5'd24;
  localparam logic [15:0] CrcPoly     = 16'h1021;
  localparam logic [15:0] CrcInit     = 16'hFFFF;
  localparam logic [31:0] VersionInit = 32'd1;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_LENGTH   = 3'd1,
    STAT_MAGIC    = 3'd2,
    STAT_VERSION  = 3'd3,
    STAT_RESERVED = 3'd4,
    STAT_CRC      = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } rec_in_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] version_word;
    logic [31:0] reserved_word;
    logic [31:0] stream_ident;
    logic [31:0] stream_era;
    logic [31:0] last_op;
  } rec_out_t;

  // end-of-record summary handed from front to back
  typedef struct packed {
    logic                         len_ok;
    logic                         magic_ok;
    logic [NumWords-1:0][31:0]    words;
    logic [15:0]                  crc;
    logic [15:0]                  stored_crc;
  } rec_sum_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    unique case (idx)
      2'd0:    m = 8'h4E;
      2'd1:    m = 8'h38;
      2'd2:    m = 8'h41;
      default: m = 8'h4D;
    endcase
    return m;
  endfunction

endpackage

[rtl/metadata_record_checker_core.sv]
// Top level of the metadata record checker: config register, front, queue, back.
// Depends on mrc_pkg, mrc_front, mrc_queue, mrc_back.
//
//   channel   handshake            payload
//   input     push / full          rec_i     (rec_in_t, one byte word)
//   result    empty / pop          res_o     (rec_out_t, one per record)
//   config    psel/penable/pwrite  paddr, pwdata, prdata (expected_version at 0)
//
// One byte word per cycle while full is low. A record's result goes from the queue through
// the zero-byte CRC stage into the result register. Reset clears counters and
// valid bits and sets expected_version to 1. A stalled result side fills the two-entry
// queue and then raises full; until then bytes keep flowing.
module metadata_record_checker_core
  import mrc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  rec_in_t     rec_i,
  output logic        empty,
  input  logic        pop,
  output rec_out_t    res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] expected_version_q;
  logic        accept, sum_push, q_pop, q_empty, reg_sel;
  rec_sum_t    sum, q_head;

  assign pready  = 1'b1;
  assign reg_sel = ~paddr[2];
  assign prdata  = reg_sel ? expected_version_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_version_q <= VersionInit;
    end else if (psel && penable && pwrite && reg_sel) begin
      expected_version_q <= pwdata;
    end
  end

  assign accept = push & ~full;

  mrc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rec_i      (rec_i),
    .sum_push_o (sum_push),
    .sum_o      (sum)
  );

  mrc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (sum_push),
    .wdata_i (sum),
    .pop_i   (q_pop),
    .rdata_o (q_head),
    .full_o  (full),
    .empty_o (q_empty)
  );

  mrc_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_empty_i          (q_empty),
    .q_head_i           (q_head),
    .q_pop_o            (q_pop),
    .expected_version_i (expected_version_q),
    .pop_i              (pop),
    .empty_o            (empty),
    .res_o              (res_o)
  );

endmodule

[rtl/mrc_front.sv]
// Front end: takes record bytes, tracks count, magic, field words and running CRC.
// Emits one summary word per record into the queue. Depends on mrc_pkg.
module mrc_front
  import mrc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  rec_in_t  rec_i,
  output logic     sum_push_o,
  output rec_sum_t sum_o
);

  logic [4:0]                count_q, count_d;
  logic [15:0]               crc_q, crc_d;
  logic                      magic_q, magic_d;
  logic [NumWords-1:0][31:0] words_q, words_d;
  logic [15:0]               stored_q, stored_d;
  logic [4:0]                off;

  always_comb begin
    count_d  = count_q;
    crc_d    = crc_q;
    magic_d  = magic_q;
    words_d  = words_q;
    stored_d = stored_q;
    off      = count_q - MagicEnd;
    if (count_q < MagicEnd) begin
      if (rec_i.data_byte != magic_byte(count_q[1:0])) begin
        magic_d = 1'b0;
      end
    end else if (count_q < FieldEnd) begin
      words_d[off[4:2]][{off[1:0], 3'b000} +: 8] = rec_i.data_byte;
      crc_d = crc_byte(crc_q, rec_i.data_byte);
    end else if (count_q < RecLen) begin
      stored_d[{count_q[0], 3'b000} +: 8] = rec_i.data_byte;
    end
    if (count_q < CountSat) begin
      count_d = count_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      crc_q   <= CrcInit;
      magic_q <= 1'b1;
    end else if (accept_i) begin
      if (rec_i.last_byte) begin
        count_q <= '0;
        crc_q   <= CrcInit;
        magic_q <= 1'b1;
      end else begin
        count_q <= count_d;
        crc_q   <= crc_d;
        magic_q <= magic_d;
      end
    end
  end

  // fully rewritten in every 26-byte record before use
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      words_q  <= words_d;
      stored_q <= stored_d;
    end
  end

  assign sum_push_o       = accept_i & rec_i.last_byte;
  assign sum_o.len_ok     = (count_d == RecLen);
  assign sum_o.magic_ok   = magic_d;
  assign sum_o.words      = words_d;
  assign sum_o.crc        = crc_d;
  assign sum_o.stored_crc = stored_d;

endmodule

[rtl/mrc_queue.sv]
// Short queue of record summaries between front and back.
// Depends on mrc_pkg.
module mrc_queue
  import mrc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  rec_sum_t wdata_i,
  input  logic     pop_i,
  output rec_sum_t rdata_o,
  output logic     full_o,
  output logic     empty_o
);

  rec_sum_t               mem_q [QueueDepth];
  logic [QueueIdxW-1:0]   wr_q, rd_q;
  logic [QueueCntW-1:0]   cnt_q;
  logic                   do_push, do_pop;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QueueIdxW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == QueueIdxW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QueueCntW'(1);
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - QueueCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

[rtl/mrc_back.sv]
// Back end: finishes the CRC over two zero bytes, grades the record, holds the result word.
// Depends on mrc_pkg.
module mrc_back
  import mrc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  rec_sum_t    q_head_i,
  output logic        q_pop_o,
  input  logic [31:0] expected_version_i,
  input  logic        pop_i,
  output logic        empty_o,
  output rec_out_t    res_o
);

  logic        s1_valid_q;
  rec_sum_t    s1_sum_q;
  logic [15:0] s1_crc_q;
  logic        out_valid_q;
  rec_out_t    res_q, res_d;
  logic        out_ready, s1_adv, take;
  logic [15:0] crc_fin;

  assign out_ready = ~out_valid_q | pop_i;
  assign s1_adv    = s1_valid_q & out_ready;
  assign take      = ~q_empty_i & (~s1_valid_q | out_ready);
  assign q_pop_o   = take;
  assign crc_fin   = crc_byte(s1_crc_q, 8'h00);

  always_comb begin
    res_d.version_word   = s1_sum_q.words[0];
    res_d.reserved_word  = s1_sum_q.words[1];
    res_d.stream_ident   = s1_sum_q.words[2];
    res_d.stream_era     = s1_sum_q.words[3];
    res_d.last_op        = s1_sum_q.words[4];
    priority if (!s1_sum_q.len_ok) begin
      res_d.status = STAT_LENGTH;
    end else if (!s1_sum_q.magic_ok) begin
      res_d.status = STAT_MAGIC;
    end else if (s1_sum_q.words[0] != expected_version_i) begin
      res_d.status = STAT_VERSION;
    end else if (s1_sum_q.words[1] != '0) begin
      res_d.status = STAT_RESERVED;
    end else if (crc_fin != s1_sum_q.stored_crc) begin
      res_d.status = STAT_CRC;
    end else begin
      res_d.status = STAT_OK;
    end
    if (!s1_sum_q.len_ok || !s1_sum_q.magic_ok) begin
      res_d.version_word   = '0;
      res_d.reserved_word  = '0;
      res_d.stream_ident   = '0;
      res_d.stream_era     = '0;
      res_d.last_op        = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_sum_q <= q_head_i;
      s1_crc_q <= crc_byte(q_head_i.crc, 8'h00);
    end
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign empty_o = ~out_valid_q;
  assign res_o   = res_q;

endmodule
